### rtl/abtc_pkg.sv
package abtc_pkg;

    localparam int CHANNELS    = 16;
    localparam int TIME_POINTS = 16;
    localparam int LINE_W      = 16;
    localparam int CH_W        = 4;
    localparam int TIME_W      = 4;
    localparam int OFFSET_W    = 8;
    localparam int GAIN_W      = 16;
    localparam int VALUE_W     = 16;

    // only the low 12 bits of a channel word matter: time points 4..15
    localparam int CODE_BITS   = 12;
    localparam int KEPT_TIMES  = CODE_BITS;
    localparam int FIRST_KEPT  = TIME_POINTS - CODE_BITS;
    localparam int GATHER_W    = 4;

    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_CAL    = 1'b1;
    localparam logic CONV_FIRST  = 1'b0;
    localparam logic CONV_SECOND = 1'b1;

    localparam logic [GAIN_W-1:0] GAIN_ONE = 16'h8000;

    // datapath widths
    localparam int D_W      = 13;
    localparam int PROD_W   = 30;
    localparam int MAG_W    = 28;
    localparam int X_W      = 30;
    localparam int Y_W      = 25;
    localparam int RECIP_W  = 26;
    localparam int P_W      = 51;
    localparam int Q_W      = 16;
    localparam int R_W      = 11;
    localparam int LANE_STAGES = 6;

    // v = round(d*gain * 25600 / (4095*32768)) = floor((5m + 13104) / 26208)
    // 26208 = 32 * 819; divide by 819 with a reciprocal and one correction
    localparam logic [X_W-1:0]     ROUND_BIAS    = 30'd13104;
    localparam int                 DIV_PRE_SHIFT = 5;
    localparam logic [Y_W-1:0]     DIV_ODD       = 25'd819;
    localparam logic [RECIP_W-1:0] RECIP         = 26'd41953282;
    localparam int                 RECIP_SHIFT   = 35;

    typedef logic [LINE_W-1:0] line_t;
    typedef logic [KEPT_TIMES-1:0][LINE_W-1:0] snap_t;

    typedef struct packed {
        logic                       is_frame;
        logic                       converter;
        logic [CH_W-1:0]            channel;
        logic signed [OFFSET_W-1:0] offset;
        logic [GAIN_W-1:0]          gain;
    } cmd_t;

endpackage

### rtl/abtc_cmd_queue.sv
module abtc_cmd_queue
    import abtc_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output logic pop_valid,
    output cmd_t pop_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/abtc_front.sv
module abtc_front
    import abtc_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       func,
    input  logic [LINE_W-1:0]          line_first,
    input  logic [LINE_W-1:0]          line_second,
    input  logic                       cal_converter,
    input  logic [CH_W-1:0]            cal_channel,
    input  logic signed [OFFSET_W-1:0] cal_offset,
    input  logic [GAIN_W-1:0]          cal_gain,
    input  logic                       q_full,
    output logic                       push,
    output cmd_t                       push_data,
    input  logic                       snap_free,
    output snap_t                      snap_first,
    output snap_t                      snap_second
);

    logic [TIME_W-1:0] time_reg, time_next;
    logic              snap_full_reg, snap_full_next;
    line_t             gather_first_reg  [KEPT_TIMES-1];
    line_t             gather_second_reg [KEPT_TIMES-1];
    snap_t             snap_first_reg, snap_second_reg;
    logic              last_time, accept, take_sample, close_frame;
    logic [GATHER_W-1:0] gather_idx;

    assign last_time   = (time_reg == TIME_W'(TIME_POINTS - 1));
    assign in_stall    = (func == FUNC_CAL) ? q_full : (last_time && (snap_full_reg || q_full));
    assign accept      = in_valid && !in_stall;
    assign take_sample = accept && (func == FUNC_SAMPLE);
    assign close_frame = take_sample && last_time;
    assign gather_idx  = GATHER_W'(time_reg - TIME_W'(FIRST_KEPT));

    assign push                = (accept && (func == FUNC_CAL)) || close_frame;
    assign push_data.is_frame  = (func == FUNC_SAMPLE);
    assign push_data.converter = cal_converter;
    assign push_data.channel   = cal_channel;
    assign push_data.offset    = cal_offset;
    assign push_data.gain      = cal_gain;

    assign snap_first  = snap_first_reg;
    assign snap_second = snap_second_reg;

    always_comb
    begin
        time_next      = time_reg;
        snap_full_next = snap_full_reg;
        if (take_sample)
        begin
            time_next = last_time ? '0 : time_reg + 1'b1;
        end
        if (close_frame)
        begin
            snap_full_next = 1'b1;
        end
        else if (snap_free)
        begin
            snap_full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg      <= '0;
            snap_full_reg <= 1'b0;
        end
        else
        begin
            time_reg      <= time_next;
            snap_full_reg <= snap_full_next;
        end
    end

    // time points before FIRST_KEPT only land in bits dropped by the code mask
    always_ff @(posedge clk)
    begin
        if (take_sample && !last_time && (time_reg >= TIME_W'(FIRST_KEPT)))
        begin
            gather_first_reg[gather_idx]  <= line_first;
            gather_second_reg[gather_idx] <= line_second;
        end
        if (close_frame)
        begin
            for (int k = 0; k < KEPT_TIMES - 1; k++)
            begin
                snap_first_reg[k]  <= gather_first_reg[k];
                snap_second_reg[k] <= gather_second_reg[k];
            end
            snap_first_reg[KEPT_TIMES-1]  <= line_first;
            snap_second_reg[KEPT_TIMES-1] <= line_second;
        end
    end

endmodule

### rtl/abtc_cal_lane.sv
module abtc_cal_lane
    import abtc_pkg::*;
(
    input  logic                       clk,
    input  logic                       en,
    input  logic [CODE_BITS-1:0]       code,
    input  logic signed [OFFSET_W-1:0] offset,
    input  logic [GAIN_W-1:0]          gain,
    output logic signed [VALUE_W-1:0]  value
);

    logic signed [D_W-1:0]    code_s, off_s, d_next, d_reg;
    logic [GAIN_W-1:0]        gain_reg;
    logic signed [PROD_W-1:0] prod_next, prod_reg, prod_abs;
    logic [MAG_W-1:0]         mag;
    logic [X_W-1:0]           x;
    logic [Y_W-1:0]           y_next, y3_reg, y4_reg;
    logic [P_W-1:0]           p;
    logic [Q_W-1:0]           q0_next, q4_reg, q5_reg;
    logic [Y_W-1:0]           r_full;
    logic [R_W-1:0]           r_reg;
    logic                     neg3_reg, neg4_reg, neg5_reg;
    logic signed [Q_W:0]      q, v;
    logic signed [VALUE_W-1:0] value_next, value_reg;

    assign code_s = $signed({code[CODE_BITS-1], code});
    assign off_s  = $signed({{(D_W - OFFSET_W){offset[OFFSET_W-1]}}, offset});
    assign d_next = -code_s - off_s;

    assign prod_next = PROD_W'(d_reg) * $signed(PROD_W'({1'b0, gain_reg}));

    assign prod_abs = prod_reg[PROD_W-1] ? -prod_reg : prod_reg;
    assign mag      = prod_abs[MAG_W-1:0];
    assign x        = (X_W'(mag) << 2) + X_W'(mag) + ROUND_BIAS;
    assign y_next   = x[X_W-1:DIV_PRE_SHIFT];

    // quotient estimate is exact or one low
    assign p       = P_W'(y3_reg) * P_W'(RECIP);
    assign q0_next = p[RECIP_SHIFT +: Q_W];

    assign r_full = y4_reg - Y_W'(q4_reg) * DIV_ODD;

    always_comb
    begin
        q = $signed({1'b0, q5_reg});
        if (r_reg >= R_W'(DIV_ODD))
        begin
            q = q + (Q_W + 1)'(1);
        end
        v = neg5_reg ? -q : q;
        if (v > $signed((Q_W + 1)'(32767)))
        begin
            value_next = 16'sh7fff;
        end
        else if (v < -$signed((Q_W + 1)'(32768)))
        begin
            value_next = 16'sh8000;
        end
        else
        begin
            value_next = v[VALUE_W-1:0];
        end
    end

    assign value = value_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg     <= d_next;
            gain_reg  <= gain;
            prod_reg  <= prod_next;
            y3_reg    <= y_next;
            neg3_reg  <= prod_reg[PROD_W-1];
            q4_reg    <= q0_next;
            y4_reg    <= y3_reg;
            neg4_reg  <= neg3_reg;
            q5_reg    <= q4_reg;
            r_reg     <= r_full[R_W-1:0];
            neg5_reg  <= neg4_reg;
            value_reg <= value_next;
        end
    end

endmodule

### rtl/abtc_back.sv
module abtc_back
    import abtc_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    input  cmd_t                       q_data,
    output logic                       q_pop,
    input  snap_t                      snap_first,
    input  snap_t                      snap_second,
    output logic                       snap_free,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [CH_W-1:0]            channel,
    output logic signed [VALUE_W-1:0]  value_first,
    output logic signed [VALUE_W-1:0]  value_second,
    output logic                       last
);

    logic                       busy_reg, busy_next;
    logic [CH_W-1:0]            ch_reg, ch_next;
    logic [LANE_STAGES-1:0]     vld_reg;
    logic [CH_W-1:0]            ch_pipe_reg   [LANE_STAGES];
    logic                       last_pipe_reg [LANE_STAGES];
    logic signed [OFFSET_W-1:0] offset_first_reg  [CHANNELS];
    logic signed [OFFSET_W-1:0] offset_second_reg [CHANNELS];
    logic [GAIN_W-1:0]          gain_first_reg  [CHANNELS];
    logic [GAIN_W-1:0]          gain_second_reg [CHANNELS];
    logic [CODE_BITS-1:0]       code_first, code_second;
    logic                       en, issue, last_ch, cal_write;

    assign en        = !(vld_reg[LANE_STAGES-1] && out_stall);
    assign q_pop     = q_valid && !busy_reg;
    assign cal_write = q_pop && !q_data.is_frame;
    assign issue     = busy_reg && en;
    assign last_ch   = (ch_reg == CH_W'(CHANNELS - 1));
    assign snap_free = issue && last_ch;

    // corner turn: code bit k of channel c is bit c of time point 15-k
    always_comb
    begin
        for (int k = 0; k < CODE_BITS; k++)
        begin
            code_first[k]  = snap_first[KEPT_TIMES-1-k][ch_reg];
            code_second[k] = snap_second[KEPT_TIMES-1-k][ch_reg];
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        ch_next   = ch_reg;
        if (q_pop && q_data.is_frame)
        begin
            busy_next = 1'b1;
            ch_next   = '0;
        end
        else if (issue)
        begin
            busy_next = !last_ch;
            ch_next   = ch_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ch_reg   <= '0;
            vld_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            ch_reg   <= ch_next;
            if (en)
            begin
                vld_reg <= {vld_reg[LANE_STAGES-2:0], issue};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ch_pipe_reg[0]   <= ch_reg;
            last_pipe_reg[0] <= last_ch;
            for (int s = 1; s < LANE_STAGES; s++)
            begin
                ch_pipe_reg[s]   <= ch_pipe_reg[s-1];
                last_pipe_reg[s] <= last_pipe_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                offset_first_reg[i]  <= '0;
                offset_second_reg[i] <= '0;
                gain_first_reg[i]    <= GAIN_ONE;
                gain_second_reg[i]   <= GAIN_ONE;
            end
        end
        else if (cal_write)
        begin
            if (q_data.converter == CONV_SECOND)
            begin
                offset_second_reg[q_data.channel] <= q_data.offset;
                gain_second_reg[q_data.channel]   <= q_data.gain;
            end
            else
            begin
                offset_first_reg[q_data.channel] <= q_data.offset;
                gain_first_reg[q_data.channel]   <= q_data.gain;
            end
        end
    end

    abtc_cal_lane u_lane_first
    (
        .clk    (clk),
        .en     (en),
        .code   (code_first),
        .offset (offset_first_reg[ch_reg]),
        .gain   (gain_first_reg[ch_reg]),
        .value  (value_first)
    );

    abtc_cal_lane u_lane_second
    (
        .clk    (clk),
        .en     (en),
        .code   (code_second),
        .offset (offset_second_reg[ch_reg]),
        .gain   (gain_second_reg[ch_reg]),
        .value  (value_second)
    );

    assign out_valid = vld_reg[LANE_STAGES-1];
    assign channel   = ch_pipe_reg[LANE_STAGES-1];
    assign last      = last_pipe_reg[LANE_STAGES-1];

endmodule

### rtl/adc_bit_transpose_calibrate_core.sv
// Two-ADC corner turn and calibration. Sample requests (func 0) are taken one per
// cycle; the 16th of a frame closes it, copies the gathered line words into a
// snapshot and queues it, and is held off while the previous snapshot is still
// being drained or the queue is full. With frames back to back the closing
// request waits until the previous snapshot has drained. Calibration requests
// (func 1) travel through the same queue and are held off only by a full queue,
// so a table write lands after every frame that was closed before it. The back
// end turns one channel per cycle, while the output is not stalled, through two
// six-stage calibration lanes (multiply, reciprocal divide, round, saturate): a
// frame gives 16 results on consecutive unstalled cycles, channel 0 first and
// last set on channel 15. A stalled output freezes the lanes; the intake runs
// on until the snapshot or the queue fills.
module adc_bit_transpose_calibrate_core
    import abtc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       func,
    input  logic [LINE_W-1:0]          line_first,
    input  logic [LINE_W-1:0]          line_second,
    input  logic                       cal_converter,
    input  logic [CH_W-1:0]            cal_channel,
    input  logic signed [OFFSET_W-1:0] cal_offset,
    input  logic [GAIN_W-1:0]          cal_gain,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [CH_W-1:0]            channel,
    output logic signed [VALUE_W-1:0]  value_first,
    output logic signed [VALUE_W-1:0]  value_second,
    output logic                       last
);

    logic  push, q_full, q_pop, q_valid, snap_free;
    cmd_t  push_data, q_data;
    snap_t snap_first, snap_second;

    abtc_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .line_first    (line_first),
        .line_second   (line_second),
        .cal_converter (cal_converter),
        .cal_channel   (cal_channel),
        .cal_offset    (cal_offset),
        .cal_gain      (cal_gain),
        .q_full        (q_full),
        .push          (push),
        .push_data     (push_data),
        .snap_free     (snap_free),
        .snap_first    (snap_first),
        .snap_second   (snap_second)
    );

    abtc_cmd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (q_data)
    );

    abtc_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_data       (q_data),
        .q_pop        (q_pop),
        .snap_first   (snap_first),
        .snap_second  (snap_second),
        .snap_free    (snap_free),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .channel      (channel),
        .value_first  (value_first),
        .value_second (value_second),
        .last         (last)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("request queue overflow");

    a_last_on_top: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> channel == CH_W'(CHANNELS - 1))
        else $error("last flag on wrong channel");

    a_channels_follow: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=>
            out_valid && channel == CH_W'($past(channel) + 1'b1))
        else $error("frame results not contiguous");

endmodule

### sim/adc_bit_transpose_calibrate_core_tb.sv
`timescale 1ns / 1ps

module adc_bit_transpose_calibrate_core_tb;
    import abtc_pkg::*;

    localparam int SCALE_NUM   = 100;
    localparam int SCALE_DEN   = 4095;
    localparam int GAIN_UNITY  = 32768;
    localparam int Q_SCALE     = 256;
    localparam int TABLE_DEPTH = 2 * CHANNELS;
    localparam int TOTAL_REQS  = 370;
    localparam int QUIET_FROM  = 150;
    localparam int QUIET_TO    = 240;
    localparam int HANG_LIMIT  = 5000;
    localparam int SETTLE      = 64;
    localparam int MAX_REPORTS = 60;

    typedef struct packed {
        logic                       func;
        line_t                      first;
        line_t                      second;
        logic                       conv;
        logic [CH_W-1:0]            ch;
        logic signed [OFFSET_W-1:0] ofs;
        logic [GAIN_W-1:0]          gain;
    } req_t;

    typedef struct packed {
        logic [CH_W-1:0]           channel;
        logic signed [VALUE_W-1:0] first;
        logic signed [VALUE_W-1:0] second;
        logic                      last;
    } reading_t;

    typedef struct packed {
        req_t                      req;
        logic                      pinned;
        logic [CH_W-1:0]           pin_ch;
        logic signed [VALUE_W-1:0] pin_first;
        logic signed [VALUE_W-1:0] pin_second;
    } dir_row_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic                       func = FUNC_SAMPLE;
    line_t                      line_first = '0;
    line_t                      line_second = '0;
    logic                       cal_converter = CONV_FIRST;
    logic [CH_W-1:0]            cal_channel = '0;
    logic signed [OFFSET_W-1:0] cal_offset = '0;
    logic [GAIN_W-1:0]          cal_gain = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [CH_W-1:0]            channel;
    logic signed [VALUE_W-1:0]  value_first;
    logic signed [VALUE_W-1:0]  value_second;
    logic                       last;

    logic quiet = 1'b0;
    int   errors = 0;
    int   hush = 0;
    int   reqs_sent = 0;

    // predictor state
    line_t                      gath_first [TIME_POINTS];
    line_t                      gath_second [TIME_POINTS];
    logic [TIME_W-1:0]          tpoint = '0;
    logic signed [OFFSET_W-1:0] zero_shift [TABLE_DEPTH];
    logic [GAIN_W-1:0]          gain_coef [TABLE_DEPTH];
    reading_t                   due_readings [$];

    // channel words of the directed frame
    line_t turn_first [CHANNELS];
    line_t turn_second [CHANNELS];

    adc_bit_transpose_calibrate_core dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .line_first    (line_first),
        .line_second   (line_second),
        .cal_converter (cal_converter),
        .cal_channel   (cal_channel),
        .cal_offset    (cal_offset),
        .cal_gain      (cal_gain),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .channel       (channel),
        .value_first   (value_first),
        .value_second  (value_second),
        .last          (last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic signed [VALUE_W-1:0] calib_value(
        input line_t                      word,
        input logic signed [OFFSET_W-1:0] ofs,
        input logic [GAIN_W-1:0]          g
    );
        logic signed [CODE_BITS-1:0] code;
        longint d;
        longint num;
        longint den;
        longint mag;
        longint q;
        longint v;
        code = word[CODE_BITS-1:0];
        d    = -longint'(code) - longint'(ofs);
        num  = d * SCALE_NUM * longint'(g) * Q_SCALE;
        den  = longint'(SCALE_DEN) * GAIN_UNITY;
        mag  = (num < 0) ? -num : num;
        q    = (mag + den / 2) / den;
        v    = (num < 0) ? -q : q;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[VALUE_W-1:0];
    endfunction

    // update the tables or gather a time point; the 16th closes the frame
    task automatic absorb(input req_t r);
        line_t    wf;
        line_t    ws;
        reading_t rd;
        int       entry;
        if (r.func == FUNC_CAL)
        begin
            entry             = ((r.conv == CONV_SECOND) ? CHANNELS : 0) + int'(r.ch);
            zero_shift[entry] = r.ofs;
            gain_coef[entry]  = r.gain;
        end
        else
        begin
            gath_first[tpoint]  = r.first;
            gath_second[tpoint] = r.second;
            if (tpoint == TIME_W'(TIME_POINTS - 1))
            begin
                for (int c = 0; c < CHANNELS; c++)
                begin
                    for (int t = 0; t < TIME_POINTS; t++)
                    begin
                        wf[TIME_POINTS-1-t] = gath_first[t][c];
                        ws[TIME_POINTS-1-t] = gath_second[t][c];
                    end
                    rd.channel = CH_W'(c);
                    rd.first   = calib_value(wf, zero_shift[c], gain_coef[c]);
                    rd.second  = calib_value(ws, zero_shift[CHANNELS+c],
                                             gain_coef[CHANNELS+c]);
                    rd.last    = (c == CHANNELS - 1);
                    due_readings.push_back(rd);
                end
            end
            tpoint = tpoint + 1'b1;
        end
    endtask

    task automatic push_req(input req_t r);
        quiet = (reqs_sent >= QUIET_FROM) && (reqs_sent < QUIET_TO);
        if (!quiet && $urandom_range(99) < 30)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        func          <= r.func;
        line_first    <= r.first;
        line_second   <= r.second;
        cal_converter <= r.conv;
        cal_channel   <= r.ch;
        cal_offset    <= r.ofs;
        cal_gain      <= r.gain;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        absorb(r);
        reqs_sent++;
    endtask

    function automatic dir_row_t sample_row(input int t);
        dir_row_t row;
        row          = '0;
        row.req.func = FUNC_SAMPLE;
        for (int b = 0; b < CHANNELS; b++)
        begin
            row.req.first[b]  = turn_first[b][TIME_POINTS-1-t];
            row.req.second[b] = turn_second[b][TIME_POINTS-1-t];
        end
        // calibration fields on a sample request must be ignored
        row.req.conv = t[0];
        row.req.ch   = CH_W'(TIME_POINTS - 1 - t);
        row.req.ofs  = OFFSET_W'(t * 37);
        row.req.gain = GAIN_W'(t * 4369);
        if (t == TIME_POINTS - 1)
        begin
            // channel 0 lands on +/-2.5 exactly: ties round away from zero
            row.pinned     = 1'b1;
            row.pin_ch     = '0;
            row.pin_first  = 16'sd3;
            row.pin_second = -16'sd3;
        end
        return row;
    endfunction

    function automatic dir_row_t cal_row(input logic conv, input int ch, input int ofs,
                                         input int gain);
        dir_row_t row;
        row            = '0;
        row.req.func   = FUNC_CAL;
        row.req.first  = '1;
        row.req.second = '1;
        row.req.conv   = conv;
        row.req.ch     = CH_W'(ch);
        row.req.ofs    = OFFSET_W'(ofs);
        row.req.gain   = GAIN_W'(gain);
        return row;
    endfunction

    function automatic logic [CODE_BITS-1:0] pick_code();
        case ($urandom_range(6))
            0: return 12'h800;
            1: return 12'h7FF;
            2: return 12'hFFF;
            3: return 12'h000;
            4: return 12'hCCD;
            5: return 12'h333;
            default: return CODE_BITS'($urandom);
        endcase
    endfunction

    task automatic note_mismatch(input string what, input logic signed [31:0] want,
                                 input logic signed [31:0] got);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%0t %s: expected %0d, got %0d", $time, what, want, got);
    endtask

    // result checker and output stall
    always @(posedge clk)
    begin
        reading_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_readings.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t unexpected result: channel %0d first %0d second %0d last %0d",
                             $time, channel, value_first, value_second, last);
            end
            else
            begin
                want = due_readings.pop_front();
                if (channel !== want.channel)
                    note_mismatch("channel", want.channel, channel);
                if (value_first !== want.first)
                    note_mismatch($sformatf("ch %0d value_first", want.channel),
                                  want.first, value_first);
                if (value_second !== want.second)
                    note_mismatch($sformatf("ch %0d value_second", want.channel),
                                  want.second, value_second);
                if (last !== want.last)
                    note_mismatch($sformatf("ch %0d last", want.channel), want.last, last);
            end
        end
        out_stall <= !quiet && ($urandom_range(99) < 30);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            hush <= 0;
        else if (hush == HANG_LIMIT)
        begin
            $display("adc_bit_transpose_calibrate_core: mismatch");
            $finish;
        end
        else
            hush <= hush + 1;
    end

    initial
    begin
        dir_row_t             dir_rows [$];
        req_t                 r;
        logic [CODE_BITS-1:0] code_f;
        logic [CODE_BITS-1:0] code_s;
        line_t                mask_f;
        line_t                mask_s;
        int                   kind;
        int                   idx;

        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            zero_shift[i] = '0;
            gain_coef[i]  = GAIN_ONE;
        end
        for (int t = 0; t < TIME_POINTS; t++)
        begin
            gath_first[t]  = '0;
            gath_second[t] = '0;
        end

        // code extremes on channels 1..6 and 15, tie codes on channel 0
        turn_first  = '{16'hACCD, 16'h7FFF, 16'hFFFF, 16'h0000, 16'h0001, 16'h0800,
                        16'h07FF, 16'hF5A5, 16'h3C96, 16'h9E01, 16'h4B2D, 16'hE870,
                        16'h1111, 16'h6F3A, 16'hC0DE, 16'h5800};
        turn_second = '{16'h5333, 16'h8000, 16'h0FFF, 16'hF000, 16'h0FFE, 16'h07FF,
                        16'h0800, 16'h1A5A, 16'hB3C4, 16'h2222, 16'h7E81, 16'hD00D,
                        16'h0F0F, 16'hA5F0, 16'h3003, 16'hF7FF};

        // table writes land mid-frame and apply at the next emission
        for (int t = 0; t < 3; t++)
            dir_rows.push_back(sample_row(t));
        dir_rows.push_back(cal_row(CONV_FIRST, 0, 0, 16));
        dir_rows.push_back(cal_row(CONV_SECOND, 0, 0, 16));
        for (int t = 3; t < 8; t++)
            dir_rows.push_back(sample_row(t));
        dir_rows.push_back(cal_row(CONV_FIRST, 15, -128, 16'hFFFF));
        dir_rows.push_back(cal_row(CONV_SECOND, 15, 127, 16'hFFFF));
        for (int t = 8; t < 12; t++)
            dir_rows.push_back(sample_row(t));
        dir_rows.push_back(cal_row(CONV_FIRST, 1, -128, 0));
        dir_rows.push_back(cal_row(CONV_SECOND, 1, 127, 0));
        for (int t = 12; t < TIME_POINTS; t++)
            dir_rows.push_back(sample_row(t));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[k])
        begin
            push_req(dir_rows[k].req);
            if (dir_rows[k].pinned)
            begin
                idx = due_readings.size() - CHANNELS + int'(dir_rows[k].pin_ch);
                due_readings[idx].first  = dir_rows[k].pin_first;
                due_readings[idx].second = dir_rows[k].pin_second;
            end
        end

        // whole frames with table writes sprinkled in between time points
        while (reqs_sent < TOTAL_REQS)
        begin
            kind   = $urandom_range(3);
            code_f = pick_code();
            code_s = pick_code();
            mask_f = line_t'($urandom);
            mask_s = line_t'($urandom);
            for (int t = 0; t < TIME_POINTS; t++)
            begin
                if ($urandom_range(99) < 8)
                begin
                    r.func   = FUNC_CAL;
                    r.first  = line_t'($urandom);
                    r.second = line_t'($urandom);
                    r.conv   = 1'($urandom);
                    r.ch     = CH_W'($urandom);
                    case ($urandom_range(3))
                        0: r.ofs = -8'sd128;
                        1: r.ofs = 8'sd127;
                        default: r.ofs = OFFSET_W'($urandom);
                    endcase
                    case ($urandom_range(5))
                        0: r.gain = '0;
                        1: r.gain = '1;
                        2: r.gain = GAIN_ONE;
                        3: r.gain = 16'd16;
                        default: r.gain = GAIN_W'($urandom);
                    endcase
                    push_req(r);
                end
                r.func = FUNC_SAMPLE;
                r.conv = 1'($urandom);
                r.ch   = CH_W'($urandom);
                r.ofs  = OFFSET_W'($urandom);
                r.gain = GAIN_W'($urandom);
                if (kind == 2 && t >= FIRST_KEPT)
                begin
                    // masked channels get the picked code, the rest its complement
                    r.first  = code_f[TIME_POINTS-1-t] ? mask_f : ~mask_f;
                    r.second = code_s[TIME_POINTS-1-t] ? mask_s : ~mask_s;
                end
                else if (kind == 3)
                begin
                    r.first  = line_t'($urandom & $urandom & $urandom);
                    r.second = line_t'($urandom | $urandom | $urandom);
                end
                else
                begin
                    r.first  = line_t'($urandom);
                    r.second = line_t'($urandom);
                end
                push_req(r);
            end
        end
        in_valid <= 1'b0;

        while (due_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (errors == 0)
            $display("adc_bit_transpose_calibrate_core: match");
        else
            $display("adc_bit_transpose_calibrate_core: mismatch");
        $finish;
    end

endmodule

### filelist.f
rtl/abtc_pkg.sv
rtl/abtc_cmd_queue.sv
rtl/abtc_front.sv
rtl/abtc_cal_lane.sv
rtl/abtc_back.sv
rtl/adc_bit_transpose_calibrate_core.sv
sim/adc_bit_transpose_calibrate_core_tb.sv
